// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared widths, codes, types and arithmetic helpers of the PD drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

    localparam int POS_W      = 21;
    localparam int ERR_W      = 23;
    localparam int DIFF_W     = 24;
    localparam int SKEW_W     = 22;
    localparam int GAIN_W     = 16;
    localparam int TIME_W     = 16;
    localparam int CAP_W      = 7;
    localparam int POWER_W    = 8;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 21;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
    localparam int TERM_W     = PROD_W - FRAC_W;
    localparam int SUM_W      = TERM_W + 1;

    localparam logic [CAP_W-1:0] SPEED_CAP_RESET = 7'd127;
    localparam logic [CAP_W-1:0] POWER_LIMIT     = 7'd127;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE,
        REG_TARGET,
        REG_TIMEOUT,
        REG_PROP_GAIN,
        REG_DERIV_GAIN,
        REG_SKEW_GAIN,
        REG_SPEED_CAP
    } reg_index_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } command_t;

    typedef enum logic {
        MODE_DRIVE = 1'b0,
        MODE_TURN  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_TIMEOUT,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [POS_W-1:0]  target;
        logic [TIME_W-1:0]        timeout_ms;
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        deriv_gain;
        logic [GAIN_W-1:0]        skew_gain;
        logic [CAP_W-1:0]         speed_cap;
    } cfg_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [ERR_W-1:0]  error;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SKEW_W-1:0] skew_diff;
    } stage_t;

    // q8.8 gain times signed value, divided by 256 rounding toward zero
    function automatic logic signed [TERM_W-1:0] q88_scale(
        input logic [GAIN_W-1:0]        gain,
        input logic signed [DIFF_W-1:0] x
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] adj;
        prod = $signed({1'b0, gain}) * x;
        adj  = prod[PROD_W-1] ? prod + $signed(PROD_W'(255)) : prod;
        return adj[PROD_W-1:FRAC_W];
    endfunction

    // symmetric clamp to +/- lim
    function automatic logic signed [POWER_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] x,
        input logic [CAP_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] lim_s;
        logic signed [SUM_W-1:0] res;
        lim_s = $signed(SUM_W'(lim));
        if (x > lim_s)
        begin
            res = lim_s;
        end
        else if (x < -lim_s)
        begin
            res = -lim_s;
        end
        else
        begin
            res = x;
        end
        return res[POWER_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/pdc_sample_if.sv =====
// ----------------------------------------------------------------------------
// pdc_sample_if
// Input channel: command and encoder sample with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdc_sample_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [pdc_pkg::POS_W-1:0]    right_pos;
    logic signed [pdc_pkg::POS_W-1:0]    left_pos;
    logic signed [pdc_pkg::POS_W-1:0]    turn_pos;
    logic [pdc_pkg::TIME_W-1:0]          elapsed_ms;

    modport source (
        output valid, command, right_pos, left_pos, turn_pos, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, command, right_pos, left_pos, turn_pos, elapsed_ms,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pdc_power_if.sv =====
// ----------------------------------------------------------------------------
// pdc_power_if
// Output channel: side powers and done flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdc_power_if;
    logic                                valid;
    logic                                ready;
    logic signed [pdc_pkg::POWER_W-1:0]  right_power;
    logic signed [pdc_pkg::POWER_W-1:0]  left_power;
    logic                                done_res;

    modport source (
        output valid, right_power, left_power, done_res,
        input  ready
    );
    modport sink (
        input  valid, right_power, left_power, done_res,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pd_drive_controller.sv =====
// ----------------------------------------------------------------------------
// pd_drive_controller
// PD drivetrain controller: one sample in, one pair of side powers out.
// Throughput: one sample per cycle while the output is not stalled; error stage
// register then result register.
// Last error lives in the error stage, so consecutive samples chain cleanly.
// Reset: config back to reset values (speed cap 127), last error and valids
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_drive_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pdc_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    pdc_sample_if.sink                           sample,
    pdc_power_if.source                          power
);

    pdc_pkg::cfg_t    cfg;
    logic             stage_valid;
    logic             stage_ready;
    pdc_pkg::stage_t  stage_data;

    pdc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_error_stage u_error_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .sample      (sample),
        .down_ready  (stage_ready),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    pdc_power_stage u_power_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_ready (stage_ready),
        .power       (power)
    );

endmodule

`default_nettype wire

// ===== sv/pdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pdc_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pdc_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output      pdc_pkg::cfg_t                       cfg
);

    pdc_pkg::cfg_t cfg_reg;
    pdc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pdc_pkg::REG_MODE:
                    cfg_next.mode = pdc_pkg::mode_t'(cfg_data[0]);
                pdc_pkg::REG_TARGET:
                    cfg_next.target = $signed(cfg_data[pdc_pkg::POS_W-1:0]);
                pdc_pkg::REG_TIMEOUT:
                    cfg_next.timeout_ms = cfg_data[pdc_pkg::TIME_W-1:0];
                pdc_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain = cfg_data[pdc_pkg::GAIN_W-1:0];
                pdc_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = cfg_data[pdc_pkg::GAIN_W-1:0];
                pdc_pkg::REG_SKEW_GAIN:
                    cfg_next.skew_gain = cfg_data[pdc_pkg::GAIN_W-1:0];
                pdc_pkg::REG_SPEED_CAP:
                    cfg_next.speed_cap = cfg_data[pdc_pkg::CAP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= pdc_pkg::MODE_DRIVE;
            cfg_reg.target     <= '0;
            cfg_reg.timeout_ms <= '0;
            cfg_reg.prop_gain  <= '0;
            cfg_reg.deriv_gain <= '0;
            cfg_reg.skew_gain  <= '0;
            cfg_reg.speed_cap  <= pdc_pkg::SPEED_CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/pdc_error_stage.sv =====
// ----------------------------------------------------------------------------
// pdc_error_stage
// Takes a sample, forms the position error, its change and the side skew, keeps last error.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_error_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pdc_pkg::cfg_t     cfg,
    pdc_sample_if.sink             sample,
    input  wire logic              down_ready,
    output      logic              stage_valid,
    output      pdc_pkg::stage_t   stage_data
);

    localparam int POS_W  = pdc_pkg::POS_W;
    localparam int ERR_W  = pdc_pkg::ERR_W;
    localparam int DIFF_W = pdc_pkg::DIFF_W;
    localparam int SKEW_W = pdc_pkg::SKEW_W;

    logic                     valid_reg;
    logic                     valid_next;
    pdc_pkg::stage_t          data_reg;
    pdc_pkg::stage_t          data_next;
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ERR_W-1:0]  last_error_next;

    logic                     take;
    logic signed [POS_W:0]    r_ext;
    logic signed [POS_W:0]    l_ext;
    logic signed [POS_W:0]    abs_r;
    logic signed [POS_W:0]    abs_l;
    logic [POS_W+1:0]         abs_sum;
    logic signed [ERR_W-1:0]  measured;
    logic signed [ERR_W-1:0]  error;
    pdc_pkg::kind_t           kind;

    assign sample.ready = !valid_reg || down_ready;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        r_ext   = (POS_W+1)'(sample.right_pos);
        l_ext   = (POS_W+1)'(sample.left_pos);
        abs_r   = r_ext[POS_W] ? -r_ext : r_ext;
        abs_l   = l_ext[POS_W] ? -l_ext : l_ext;
        abs_sum = {1'b0, abs_r} + {1'b0, abs_l};

        // drive mode averages the absolute side positions
        if (cfg.mode == pdc_pkg::MODE_DRIVE)
        begin
            measured = $signed(ERR_W'(abs_sum[POS_W+1:1]));
        end
        else
        begin
            measured = ERR_W'(sample.turn_pos);
        end
        error = ERR_W'(cfg.target) - measured;

        if (sample.command == pdc_pkg::CMD_START)
        begin
            kind = pdc_pkg::KIND_START;
        end
        else if (sample.elapsed_ms >= cfg.timeout_ms)
        begin
            kind = pdc_pkg::KIND_TIMEOUT;
        end
        else
        begin
            kind = pdc_pkg::KIND_RUN;
        end

        data_next.kind      = kind;
        data_next.error     = error;
        data_next.diff      = DIFF_W'(error) - DIFF_W'(last_error_reg);
        data_next.skew_diff = SKEW_W'(sample.right_pos) - SKEW_W'(sample.left_pos);

        last_error_next = last_error_reg;
        valid_next      = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
            case (kind)
                pdc_pkg::KIND_START:   last_error_next = '0;
                pdc_pkg::KIND_RUN:     last_error_next = error;
                pdc_pkg::KIND_TIMEOUT: last_error_next = last_error_reg;
                default:               last_error_next = last_error_reg;
            endcase
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            last_error_reg <= last_error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/pdc_power_stage.sv =====
// ----------------------------------------------------------------------------
// pdc_power_stage
// Gain products, PD clamp and, in drive mode, skew correction and side
// saturation into the result register; a timeout sample raises done.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_power_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pdc_pkg::cfg_t     cfg,
    input  wire logic              stage_valid,
    input  wire pdc_pkg::stage_t   stage_data,
    output      logic              stage_ready,
    pdc_power_if.source            power
);

    localparam int DIFF_W  = pdc_pkg::DIFF_W;
    localparam int TERM_W  = pdc_pkg::TERM_W;
    localparam int SUM_W   = pdc_pkg::SUM_W;
    localparam int POWER_W = pdc_pkg::POWER_W;

    logic                       valid_reg;
    logic signed [POWER_W-1:0]  right_reg;
    logic signed [POWER_W-1:0]  left_reg;
    logic                       done_reg;
    logic signed [POWER_W-1:0]  right_next;
    logic signed [POWER_W-1:0]  left_next;
    logic                       done_next;

    logic signed [TERM_W-1:0]   p_term;
    logic signed [TERM_W-1:0]   d_term;
    logic signed [TERM_W-1:0]   k_term;
    logic signed [SUM_W-1:0]    pd_sum;
    logic signed [POWER_W-1:0]  pd;

    assign stage_ready = !valid_reg || power.ready;

    always_comb
    begin
        p_term = pdc_pkg::q88_scale(cfg.prop_gain, DIFF_W'(stage_data.error));
        d_term = pdc_pkg::q88_scale(cfg.deriv_gain, stage_data.diff);
        k_term = pdc_pkg::q88_scale(cfg.skew_gain, DIFF_W'(stage_data.skew_diff));
        pd_sum = SUM_W'(p_term) + SUM_W'(d_term);
        pd     = pdc_pkg::clamp_sym(pd_sum, cfg.speed_cap);

        right_next = '0;
        left_next  = '0;
        done_next  = 1'b0;
        case (stage_data.kind)
            pdc_pkg::KIND_RUN:
            begin
                if (cfg.mode == pdc_pkg::MODE_DRIVE)
                begin
                    right_next = pdc_pkg::clamp_sym(SUM_W'(pd) - SUM_W'(k_term),
                                                    pdc_pkg::POWER_LIMIT);
                    left_next  = pdc_pkg::clamp_sym(SUM_W'(pd) + SUM_W'(k_term),
                                                    pdc_pkg::POWER_LIMIT);
                end
                else
                begin
                    right_next = pd;
                    left_next  = pd;
                end
            end
            pdc_pkg::KIND_TIMEOUT:
                done_next = 1'b1;
            pdc_pkg::KIND_START:
                done_next = 1'b0;
            default:
                done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && stage_valid)
        begin
            right_reg <= right_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

    assign power.valid       = valid_reg;
    assign power.right_power = right_reg;
    assign power.left_power  = left_reg;
    assign power.done_res    = done_reg;

endmodule

`default_nettype wire
